// ===== rtl/pafm_pkg.sv =====
package pafm_pkg;

    // field widths
    localparam int IncW   = 25;
    localparam int CvW    = 12;
    localparam int SpanW  = 26;
    localparam int PhaseW = 25;
    localparam int CfgW   = 26;
    localparam int CfgIdxW = 1;

    // working value width for the phase arithmetic
    localparam int VW = 40;

    // serial multiplier
    localparam int MulAW   = 28;
    localparam int MulBW   = 26;
    localparam int MulHiW  = 30;
    localparam int ProdW   = MulHiW + MulBW;
    localparam int MulCntW = $clog2(MulBW);
    localparam int BiasW   = 16;

    // serial divider
    localparam int DivNW   = 27;
    localparam int DivDW   = 12;
    localparam int DivCntW = $clog2(DivNW);

    // shifts
    localparam int FmShift  = 11;
    localparam int PmShift  = 11;
    localparam int ThrShift = 12;
    localparam int QShift   = 16;

    // constants
    localparam logic [SpanW-1:0] SPAN_MAX   = SpanW'(33554432);
    localparam logic [SpanW-1:0] SPAN_RESET = SpanW'(16777216);
    localparam logic [SpanW-1:0] SPAN_MIN   = SpanW'(1);
    localparam logic [DivNW-1:0] RECIP_NUM  = DivNW'(134215680);
    localparam logic [CvW-1:0]   CV_FULL    = CvW'(4095);
    localparam logic [CvW-1:0]   CV_HIGH    = CvW'(4094);
    localparam logic [CvW-1:0]   CV_LOW     = CvW'(1);
    localparam logic [BiasW-1:0] RND_Q16    = BiasW'(32768);
    localparam logic [BiasW-1:0] RND_THR    = BiasW'(2048);

    typedef enum logic [1:0] {
        MODE_ROOT = 2'd0,
        MODE_DUTY = 2'd1,
        MODE_FM   = 2'd2,
        MODE_PM   = 2'd3
    } t_mode;

    localparam logic [CfgIdxW-1:0] REG_MODE = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] REG_SPAN = CfgIdxW'(1);

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

// ===== rtl/pafm_mul.sv =====
module pafm_mul
    import pafm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [MulAW-1:0]  i_mcand,
    input  logic [MulBW-1:0]         i_mplier,
    input  logic [BiasW-1:0]         i_bias,
    output logic signed [ProdW-1:0]  o_prod,
    output t_unit_stat               o_stat
);

    logic                      r_busy;
    logic                      r_done;
    logic [MulCntW-1:0]        r_cnt;
    logic signed [MulAW-1:0]   r_a;
    logic [MulBW-1:0]          r_b;
    logic signed [MulHiW-1:0]  r_hi;
    logic [MulBW-1:0]          r_lo;

    logic signed [MulHiW-1:0]  addend;
    logic signed [MulHiW-1:0]  sum;

    // one multiplier bit per cycle, accumulator shifts right
    assign addend = r_b[0] ? {{(MulHiW-MulAW){r_a[MulAW-1]}}, r_a} : '0;
    assign sum    = r_hi + addend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MulCntW'(MulBW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_mcand;
            r_b  <= i_mplier;
            r_hi <= {{(MulHiW-BiasW){1'b0}}, i_bias};
            r_lo <= '0;
        end else if (r_busy) begin
            r_b  <= {1'b0, r_b[MulBW-1:1]};
            r_hi <= {sum[MulHiW-1], sum[MulHiW-1:1]};
            r_lo <= {sum[0], r_lo[MulBW-1:1]};
        end
    end

    assign o_prod      = {r_hi, r_lo};
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

`ifndef SYNTHESIS
    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("multiplier done without a run");
`endif

endmodule

// ===== rtl/pafm_div.sv =====
module pafm_div
    import pafm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DivNW-1:0]   i_dvd,
    input  logic [DivDW-1:0]   i_dvs,
    output logic [DivNW-1:0]   o_quo,
    output t_unit_stat         o_stat
);

    logic               r_busy;
    logic               r_done;
    logic [DivCntW-1:0] r_cnt;
    logic [DivNW-1:0]   r_q;
    logic [DivDW-1:0]   r_rem;
    logic [DivDW-1:0]   r_dvs;

    logic [DivDW:0]     trial;
    logic               ge;
    logic [DivDW:0]     diff;

    // restoring division, one quotient bit per cycle
    assign trial = {r_rem, r_q[DivNW-1]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DivCntW'(DivNW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dvd;
            r_rem <= '0;
            r_dvs <= i_dvs;
        end else if (r_busy) begin
            r_q   <= {r_q[DivNW-2:0], ge};
            r_rem <= ge ? diff[DivDW-1:0] : trial[DivDW-1:0];
        end
    end

    assign o_quo       = r_q;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

`ifndef SYNTHESIS
    a_rem_below_dvs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !$past(i_start) |-> r_rem < r_dvs)
        else $error("divider remainder not below divisor");
`endif

endmodule

// ===== rtl/phase_accumulator_four_modes_top.sv =====
// one word in flight: a new input word is accepted only in idle, and the sequencer
// returns to idle once the result word is loaded into the output register
// the serial multiplier and divider set the long paths
// synchronous active-low reset: mode root, span 16777216, phase, hidden phase and
// previous cv cleared, no result pending
module phase_accumulator_four_modes_top
    import pafm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write port
    input  logic                     i_cfg_we,
    input  logic [CfgIdxW-1:0]       i_cfg_index,
    input  logic [CfgW-1:0]          i_cfg_data,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [IncW-1:0]   i_attack_increment,
    input  logic signed [IncW-1:0]   i_release_increment,
    input  logic                     i_in_attack,
    input  logic [CvW-1:0]           i_cv_sample,
    input  logic [CvW-1:0]           i_cv_average,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [PhaseW-1:0]        o_phase
);

    // sequencer states, one-hot
    typedef enum logic [16:0] {
        S_IDLE    = 17'b00000000000000001,
        S_START   = 17'b00000000000000010,
        S_FM_MUL  = 17'b00000000000000100,
        S_CLAMP   = 17'b00000000000001000,
        S_ADD_INC = 17'b00000000000010000,
        S_WRAP1   = 17'b00000000000100000,
        S_WRAP2   = 17'b00000000001000000,
        S_FIN     = 17'b00000000010000000,
        S_HWRAP1  = 17'b00000000100000000,
        S_HWRAP2  = 17'b00000001000000000,
        S_HSAVE   = 17'b00000010000000000,
        S_THR_MUL = 17'b00000100000000000,
        S_DIV     = 17'b00001000000000000,
        S_HK_MUL  = 17'b00010000000000000,
        S_SK_MUL  = 17'b00100000000000000,
        S_SPARE0  = 17'b01000000000000000,
        S_SPARE1  = 17'b10000000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // configuration registers
    t_mode              r_mode;
    logic [SpanW-1:0]   r_span_twice;

    // architectural state
    logic [PhaseW-1:0]  r_phase;
    logic [PhaseW-1:0]  r_hidden;
    logic [CvW-1:0]     r_prev;

    // word latched at acceptance
    logic signed [IncW-1:0] r_atk;
    logic signed [IncW-1:0] r_rel;
    logic                   r_att;
    logic [CvW-1:0]         r_cv;
    logic [CvW-1:0]         r_avg;
    logic [SpanW-1:0]       r_span;

    // working registers
    logic signed [VW-1:0]   r_v;
    logic [DivNW-1:0]       r_k;
    logic                   r_below;

    // output register
    logic                   r_out_valid;
    logic [PhaseW-1:0]      r_out_phase;

    // serial units; the multiplier is shared by the fm and duty steps
    logic                   mul_start;
    logic signed [MulAW-1:0] mul_a;
    logic [MulBW-1:0]       mul_b;
    logic [BiasW-1:0]       mul_bias;
    logic signed [ProdW-1:0] mul_prod;
    t_unit_stat             mul_stat;

    logic                   div_start;
    logic [DivDW-1:0]       div_dvs;
    logic [DivNW-1:0]       div_quo;
    t_unit_stat             div_stat;

    // combinational helpers
    logic                   in_acc;
    logic                   out_free;
    logic                   out_load;
    logic [SpanW-1:0]       span_eff;
    logic [SpanW-1:0]       span_m1;
    logic signed [VW-1:0]   span_v;
    logic signed [VW-1:0]   phase_v;
    logic signed [VW-1:0]   hidden_v;
    logic signed [IncW-1:0] inc_sel;
    logic signed [VW-1:0]   inc_v;
    logic signed [VW-1:0]   atk_v;
    logic signed [CvW:0]    cv_d;
    logic signed [VW-1:0]   cvd_v;
    logic [CvW-1:0]         avg_c;
    logic [CvW-1:0]         a_duty;
    logic [CvW-1:0]         fm_m;
    logic signed [VW-1:0]   wrap_dn;
    logic signed [VW-1:0]   wrap_up;
    logic [PhaseW-1:0]      wrap_fin;
    logic signed [VW-1:0]   clamp_v;
    logic signed [VW-1:0]   fm_step;
    logic signed [VW-1:0]   q_prod;
    logic                   thr_below;

    // handshakes: a new word only from idle, result held until taken
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign out_load   = (r_state == S_FIN) && out_free;

    // effective span: zero acts as one, above the table limit saturates
    assign span_eff = (r_span_twice == '0)      ? SPAN_MIN :
                      (r_span_twice > SPAN_MAX) ? SPAN_MAX : r_span_twice;
    assign span_m1  = r_span - 1'b1;
    assign span_v   = $signed({{(VW-SpanW){1'b0}}, r_span});
    assign phase_v  = $signed({{(VW-PhaseW){1'b0}}, r_phase});
    assign hidden_v = $signed({{(VW-PhaseW){1'b0}}, r_hidden});

    // increment chosen by the attack flag
    assign inc_sel = r_att ? r_atk : r_rel;
    assign inc_v   = {{(VW-IncW){inc_sel[IncW-1]}}, inc_sel};
    assign atk_v   = {{(VW-IncW){r_atk[IncW-1]}}, r_atk};

    // phase modulation: cv difference scaled up
    assign cv_d  = $signed({1'b0, r_cv}) - $signed({1'b0, r_prev});
    assign cvd_v = {{(VW-CvW-1-PmShift){cv_d[CvW]}}, cv_d, {PmShift{1'b0}}};

    // duty cycle uses the clamped average, fm the raw one
    assign avg_c  = (r_avg < CV_LOW)  ? CV_LOW :
                    (r_avg > CV_HIGH) ? CV_HIGH : r_avg;
    assign a_duty = CV_FULL - avg_c;
    assign fm_m   = r_att ? (CV_FULL - r_avg) : r_avg;

    // wrap in two steps, then pin to [0, span-1]
    assign wrap_dn  = (r_v >= span_v) ? (r_v - span_v) : r_v;
    assign wrap_up  = (r_v < 0) ? (r_v + span_v) : r_v;
    assign wrap_fin = (r_v < 0)       ? '0 :
                      (r_v >= span_v) ? span_m1[PhaseW-1:0] : r_v[PhaseW-1:0];
    assign clamp_v  = (r_v < 0) ? '0 : (r_v > span_v) ? span_v : r_v;

    // product slices: floor shift for fm, q16 for the duty products
    assign fm_step = $signed(mul_prod[VW+FmShift-1:FmShift]);
    assign q_prod  = $signed(mul_prod[ProdW-1:QShift]);

    // threshold test: hidden phase below round(span * (4095 - clamped avg) / 4096)
    assign thr_below = {{(ProdW-ThrShift-PhaseW){1'b0}}, r_hidden}
                       < mul_prod[ProdW-1:ThrShift];

    // operand selection for the multiplier
    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        mul_bias  = '0;
        case (r_state)
            S_START: begin
                if (r_mode == MODE_FM) begin
                    mul_start = 1'b1;
                    mul_a     = {{(MulAW-IncW){inc_sel[IncW-1]}}, inc_sel};
                    mul_b     = {{(MulBW-CvW){1'b0}}, fm_m};
                end
            end
            S_HSAVE: begin
                mul_start = 1'b1;
                mul_a     = $signed({{(MulAW-SpanW){1'b0}}, r_span});
                mul_b     = {{(MulBW-CvW){1'b0}}, a_duty};
                mul_bias  = RND_THR;
            end
            S_DIV: begin
                mul_start = div_stat.done;
                mul_a     = $signed({{(MulAW-DivNW){1'b0}}, div_quo});
                mul_b     = {{(MulBW-PhaseW){1'b0}}, r_hidden};
                mul_bias  = RND_Q16;
            end
            S_HK_MUL: begin
                mul_start = mul_stat.done && !r_below;
                mul_a     = $signed({{(MulAW-DivNW){1'b0}}, r_k});
                mul_b     = r_span;
                mul_bias  = RND_Q16;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    // reciprocal divisor picked by the threshold test
    assign div_start = (r_state == S_THR_MUL) && mul_stat.done;
    assign div_dvs   = thr_below ? a_duty : avg_c;

    pafm_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  (mul_a),
        .i_mplier (mul_b),
        .i_bias   (mul_bias),
        .o_prod   (mul_prod),
        .o_stat   (mul_stat)
    );

    pafm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dvd   (RECIP_NUM),
        .i_dvs   (div_dvs),
        .o_quo   (div_quo),
        .o_stat  (div_stat)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_START;
            end
            S_START: begin
                if (r_mode == MODE_DUTY)    n_state = S_HWRAP1;
                else if (r_mode == MODE_FM) n_state = S_FM_MUL;
                else if (r_mode == MODE_PM) n_state = S_CLAMP;
                else                        n_state = S_WRAP1;
            end
            S_FM_MUL: begin
                if (mul_stat.done) n_state = S_CLAMP;
            end
            S_CLAMP: begin
                n_state = (r_mode == MODE_PM) ? S_ADD_INC : S_WRAP1;
            end
            S_ADD_INC: n_state = S_WRAP1;
            S_WRAP1:   n_state = S_WRAP2;
            S_WRAP2:   n_state = S_FIN;
            S_FIN: begin
                if (out_free) n_state = S_IDLE;
            end
            S_HWRAP1:  n_state = S_HWRAP2;
            S_HWRAP2:  n_state = S_HSAVE;
            S_HSAVE:   n_state = S_THR_MUL;
            S_THR_MUL: begin
                if (mul_stat.done) n_state = S_DIV;
            end
            S_DIV: begin
                if (div_stat.done) n_state = S_HK_MUL;
            end
            S_HK_MUL: begin
                if (mul_stat.done) n_state = r_below ? S_WRAP1 : S_SK_MUL;
            end
            S_SK_MUL: begin
                if (mul_stat.done) n_state = S_WRAP1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= MODE_ROOT;
            r_span_twice <= SPAN_RESET;
            r_phase      <= '0;
            r_hidden     <= '0;
            r_prev       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MODE: r_mode       <= t_mode'(i_cfg_data[1:0]);
                    REG_SPAN: r_span_twice <= i_cfg_data[SpanW-1:0];
                    default:  r_mode       <= r_mode;
                endcase
            end
            if (r_state == S_HSAVE) r_hidden <= wrap_fin;
            if (out_load) begin
                r_phase <= wrap_fin;
                r_prev  <= r_cv;
            end
            r_out_valid <= out_load || (r_out_valid && i_out_stall);
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_atk  <= i_attack_increment;
            r_rel  <= i_release_increment;
            r_att  <= i_in_attack;
            r_cv   <= i_cv_sample;
            r_avg  <= i_cv_average;
            r_span <= span_eff;
        end
        case (r_state)
            S_START: begin
                if (r_mode == MODE_DUTY)    r_v <= hidden_v + atk_v;
                else if (r_mode == MODE_PM) r_v <= phase_v + cvd_v;
                else if (r_mode != MODE_FM) r_v <= phase_v + inc_v;
            end
            S_FM_MUL: begin
                if (mul_stat.done) r_v <= phase_v + fm_step;
            end
            S_CLAMP:            r_v <= clamp_v;
            S_ADD_INC:          r_v <= r_v + inc_v;
            S_WRAP1, S_HWRAP1:  r_v <= wrap_dn;
            S_WRAP2, S_HWRAP2:  r_v <= wrap_up;
            S_THR_MUL: begin
                if (mul_stat.done) r_below <= thr_below;
            end
            S_DIV: begin
                if (div_stat.done) r_k <= div_quo;
            end
            S_HK_MUL: begin
                // below threshold: first segment, else start of second segment
                if (mul_stat.done) r_v <= r_below ? q_prod : (q_prod + span_v);
            end
            S_SK_MUL: begin
                if (mul_stat.done) r_v <= r_v - q_prod;
            end
            default: begin
                r_v <= r_v;
            end
        endcase
        if (out_load) r_out_phase <= wrap_fin;
    end

    assign o_out_valid = r_out_valid;
    assign o_phase     = r_out_phase;

`ifndef SYNTHESIS
    // a new word is never accepted while a serial unit still runs
    a_units_free_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> !mul_stat.busy && !div_stat.busy)
        else $error("word accepted while a serial unit is busy");

    // stored phase always lands inside the wrap range
    a_phase_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> ({1'b0, r_phase} < r_span))
        else $error("stored phase outside span");
`endif

endmodule
